[src/drive_command_decoder_failsafe_macros.svh]
// assertion macros for the drive command decoder
`ifndef DRIVE_COMMAND_DECODER_FAILSAFE_MACROS_SVH
`define DRIVE_COMMAND_DECODER_FAILSAFE_MACROS_SVH

`ifndef SYNTHESIS
`define DCDF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("drive command decoder assertion failed");
`define DCDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drive command decoder assertion failed");
`else
`define DCDF_ASSERT_NOW(lbl, ante, cons)
`define DCDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/dcdf_pkg.sv]
`default_nettype none

package dcdf_pkg;

    localparam int unsigned CountWidth = 17;
    localparam int unsigned DutyWidth  = 9;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [CountWidth-1:0] StopTimeoutReset = 17'd500;
    localparam logic [CountWidth-1:0] DisconnectReset  = 17'd60000;
    localparam logic [CountWidth-1:0] IdleCapReset     = 17'd70000;

    localparam logic [7:0] CommandLength = 8'd4;
    localparam logic signed [10:0] AxisCentre = 11'sd127;
    localparam logic signed [10:0] FullDuty   = 11'sd256;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_STOP_TIMEOUT = 2'd0,
        CFG_DISCONNECT   = 2'd1,
        CFG_IDLE_CAP     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 dir;
        logic [DutyWidth-1:0] duty;
    } t_motor;

    typedef struct packed {
        logic       is_cmd;
        logic       is_idle;
        logic [7:0] lamp;
        t_motor     left;
        t_motor     right;
    } t_cmd;

    typedef struct packed {
        logic       accepted;
        logic [7:0] lamp;
        t_motor     left;
        t_motor     right;
        logic       stop;
        logic       disc;
    } t_result;

    function automatic t_motor drive(input logic signed [10:0] s);
        t_motor m;
        if (s >= 0) begin
            m.dir  = 1'b1;
            m.duty = DutyWidth'(FullDuty - s);
        end else begin
            m.dir  = 1'b0;
            m.duty = DutyWidth'(-s);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[src/drive_command_decoder_failsafe.sv]
`default_nettype none

// Drive command decoder with idle failsafe. Each poll item is registered on
// input and its result is then captured in the output register once the
// output register is free to take it; one item is accepted every cycle
// while the output is not stalled; the decode, the idle
// counter update and the failsafe compare all sit in the single stage between
// the input register and the output register. Configuration writes are taken
// in any cycle and are meant to be issued only while no item is in flight.

`include "drive_command_decoder_failsafe_macros.svh"

module drive_command_decoder_failsafe (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire logic                               i_operation,
    input  wire logic [7:0]                         i_packet_length,
    input  wire logic [7:0]                         i_first_byte,
    input  wire logic [7:0]                         i_second_byte,
    input  wire logic [7:0]                         i_third_byte,
    input  wire logic [7:0]                         i_check_byte,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output      logic                               o_command_accepted,
    output      logic [7:0]                         o_lamp_duty,
    output      logic                               o_left_direction,
    output      logic [8:0]                         o_left_duty,
    output      logic                               o_right_direction,
    output      logic [8:0]                         o_right_duty,
    output      logic                               o_failsafe_stop,
    output      logic                               o_disconnected,
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [dcdf_pkg::CfgIdxWidth-1:0]   i_cfg_index,
    input  wire logic [dcdf_pkg::CountWidth-1:0]    i_cfg_data
);

    logic                            r_in_valid;
    logic                            r_operation;
    logic [7:0]                      r_packet_length;
    logic [7:0]                      r_first_byte;
    logic [7:0]                      r_second_byte;
    logic [7:0]                      r_third_byte;
    logic [7:0]                      r_check_byte;
    logic                            r_out_valid;
    dcdf_pkg::t_result               r_result;
    dcdf_pkg::t_result               result;
    dcdf_pkg::t_cmd                  cmd;
    logic [dcdf_pkg::CountWidth-1:0] r_stop_ticks;
    logic [dcdf_pkg::CountWidth-1:0] r_disc_ticks;
    logic [dcdf_pkg::CountWidth-1:0] r_idle_cap;
    logic                            out_free;
    logic                            advance;
    logic                            in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_ticks <= dcdf_pkg::StopTimeoutReset;
            r_disc_ticks <= dcdf_pkg::DisconnectReset;
            r_idle_cap   <= dcdf_pkg::IdleCapReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dcdf_pkg::CFG_STOP_TIMEOUT: r_stop_ticks <= i_cfg_data;
                dcdf_pkg::CFG_DISCONNECT:   r_disc_ticks <= i_cfg_data;
                dcdf_pkg::CFG_IDLE_CAP:     r_idle_cap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_operation     <= i_operation;
            r_packet_length <= i_packet_length;
            r_first_byte    <= i_first_byte;
            r_second_byte   <= i_second_byte;
            r_third_byte    <= i_third_byte;
            r_check_byte    <= i_check_byte;
        end
    end

    dcdf_decode u_decode (
        .i_operation     (r_operation),
        .i_packet_length (r_packet_length),
        .i_first_byte    (r_first_byte),
        .i_second_byte   (r_second_byte),
        .i_third_byte    (r_third_byte),
        .i_check_byte    (r_check_byte),
        .o_cmd           (cmd)
    );

    dcdf_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (advance),
        .i_cmd        (cmd),
        .i_stop_ticks (r_stop_ticks),
        .i_disc_ticks (r_disc_ticks),
        .i_idle_cap   (r_idle_cap),
        .o_result     (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_command_accepted = r_result.accepted;
    assign o_lamp_duty        = r_result.lamp;
    assign o_left_direction   = r_result.left.dir;
    assign o_left_duty        = r_result.left.duty;
    assign o_right_direction  = r_result.right.dir;
    assign o_right_duty       = r_result.right.duty;
    assign o_failsafe_stop    = r_result.stop;
    assign o_disconnected     = r_result.disc;

    `DCDF_ASSERT_NOW(a_stop_disc_excl, o_out_valid, !(o_failsafe_stop && o_disconnected))
    `DCDF_ASSERT_NOW(a_stop_forces_off, o_out_valid && o_failsafe_stop,
        o_lamp_duty == 8'd0 && o_left_duty == 9'd256 && o_right_duty == 9'd256)
    `DCDF_ASSERT_NEXT(a_held_item_kept, r_in_valid && !out_free, r_in_valid)

endmodule

`default_nettype wire

[src/dcdf_decode.sv]
`default_nettype none

module dcdf_decode (
    input  wire logic         i_operation,
    input  wire logic [7:0]   i_packet_length,
    input  wire logic [7:0]   i_first_byte,
    input  wire logic [7:0]   i_second_byte,
    input  wire logic [7:0]   i_third_byte,
    input  wire logic [7:0]   i_check_byte,
    output dcdf_pkg::t_cmd    o_cmd
);

    logic [7:0]         sum;
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic signed [10:0] ax;
    logic signed [10:0] ay;
    logic               spin;

    always_comb begin
        sum  = 8'(i_first_byte + i_second_byte + i_third_byte);
        x    = (signed'({3'b000, i_first_byte}) - dcdf_pkg::AxisCentre) <<< 1;
        y    = (signed'({3'b000, i_second_byte}) - dcdf_pkg::AxisCentre) <<< 1;
        ax   = (x < 0) ? -x : x;
        ay   = (y < 0) ? -y : y;
        spin = ax > ay;

        o_cmd.is_idle = !i_operation || (i_packet_length == 8'd0);
        o_cmd.is_cmd  = i_operation && (i_packet_length == dcdf_pkg::CommandLength)
                        && (sum == i_check_byte);
        o_cmd.lamp    = i_third_byte;
        o_cmd.left    = dcdf_pkg::drive(spin ? x : y);
        o_cmd.right   = dcdf_pkg::drive(spin ? -x : y);
    end

endmodule

`default_nettype wire

[src/dcdf_state.sv]
`default_nettype none

module dcdf_state (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_update,
    input  wire dcdf_pkg::t_cmd                    i_cmd,
    input  wire logic [dcdf_pkg::CountWidth-1:0]   i_stop_ticks,
    input  wire logic [dcdf_pkg::CountWidth-1:0]   i_disc_ticks,
    input  wire logic [dcdf_pkg::CountWidth-1:0]   i_idle_cap,
    output dcdf_pkg::t_result                      o_result
);

    logic [dcdf_pkg::CountWidth-1:0] r_idle_count;
    logic [dcdf_pkg::CountWidth-1:0] n_idle_count;
    logic [7:0]                      r_lamp;
    logic [7:0]                      n_lamp;
    dcdf_pkg::t_motor                r_left;
    dcdf_pkg::t_motor                n_left;
    dcdf_pkg::t_motor                r_right;
    dcdf_pkg::t_motor                n_right;
    logic                            disc;
    logic                            stop;

    always_comb begin
        n_idle_count = r_idle_count;
        n_lamp       = r_lamp;
        n_left       = r_left;
        n_right      = r_right;
        if (i_cmd.is_idle) begin
            if (r_idle_count < i_idle_cap) begin
                n_idle_count = r_idle_count + 1'b1;
            end
        end else if (i_cmd.is_cmd) begin
            n_idle_count = '0;
            n_lamp       = i_cmd.lamp;
            n_left       = i_cmd.left;
            n_right      = i_cmd.right;
        end

        disc = n_idle_count == i_disc_ticks;
        stop = !disc && (n_idle_count == i_stop_ticks);
        if (stop) begin
            n_lamp  = '0;
            n_left  = dcdf_pkg::drive(11'sd0);
            n_right = dcdf_pkg::drive(11'sd0);
        end

        o_result.accepted = i_cmd.is_cmd && !i_cmd.is_idle;
        o_result.lamp     = n_lamp;
        o_result.left     = n_left;
        o_result.right    = n_right;
        o_result.stop     = stop;
        o_result.disc     = disc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_count <= '0;
            r_lamp       <= '0;
            r_left       <= '0;
            r_right      <= '0;
        end else if (i_update) begin
            r_idle_count <= n_idle_count;
            r_lamp       <= n_lamp;
            r_left       <= n_left;
            r_right      <= n_right;
        end
    end

endmodule

`default_nettype wire
